[src/fbbr_pkg.sv]
// ----------------------------------------------------------------------------
// fbbr_pkg: shared types and constants of the flash bad-block remapper
// Transaction payloads, status codes, and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package fbbr_pkg;

  localparam int DEF_TABLE_DEPTH = 64;

  localparam logic [15:0] END_MARK          = 16'hFFFF;
  localparam logic [15:0] RST_BLOCK_SIZE    = 16'd4096;
  localparam logic [15:0] RST_BLOCKS_IN_USE = 16'h0100;

  localparam logic        CMD_LOAD  = 1'b0;
  localparam logic        CMD_XLATE = 1'b1;

  localparam logic [1:0]  ST_OK    = 2'd0;
  localparam logic [1:0]  ST_RANGE = 2'd1;
  localparam logic [1:0]  ST_LOOP  = 2'd2;

  localparam logic        REG_BLOCK_SIZE    = 1'b0;
  localparam logic        REG_BLOCKS_IN_USE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  entry_index;
    logic [15:0] entry_value;
    logic [31:0] logical_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] phys_address;
    logic [15:0] phys_block;
    logic [1:0]  status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       clear_step;
    logic       load;
    logic       accept;
    logic       div_step;
    logic       walk_init;
    logic       walk_next;
    logic       walk_hit;
    logic       mul;
    logic       res_ok;
    logic       res_zero;
    logic [1:0] res_code;
    logic       emit;
  } fbbr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic range_bad;
    logic div_last;
    logic i_at_end;
    logic entry_end;
    logic entry_hit;
    logic loop_bound;
  } fbbr_sts_t;

endpackage

[src/fbbr_dpath.sv]
// ----------------------------------------------------------------------------
// fbbr_dpath: remapper datapath
// Config registers, bad-block table memory, serial divider, table walk
// registers, final multiply-add and the output register.
// ----------------------------------------------------------------------------
module fbbr_dpath #(
  parameter int TABLE_DEPTH = fbbr_pkg::DEF_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  fbbr_pkg::in_item_t  in_data,
  input  fbbr_pkg::fbbr_cmd_t cmd,
  output fbbr_pkg::fbbr_sts_t sts,
  output fbbr_pkg::out_item_t out_data
);
  import fbbr_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = $clog2(TABLE_DEPTH + 2);

  logic [15:0]   block_size;
  logic [15:0]   blocks_in_use;
  logic [31:0]   limit;

  logic [15:0]   mem [TABLE_DEPTH];
  logic [15:0]   rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic          slot_ok;

  logic [31:0]   addr_q;     // dividend, becomes quotient
  logic [15:0]   rem;
  logic [4:0]    div_cnt;
  logic [16:0]   trial;
  logic          trial_ge;

  logic [CW-1:0] i_cnt;
  logic [RW-1:0] restarts;
  logic [15:0]   blk;
  logic [31:0]   prod;

  logic [31:0]   res_addr;
  logic [15:0]   res_blk;
  logic [1:0]    res_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size    <= RST_BLOCK_SIZE;
      blocks_in_use <= RST_BLOCKS_IN_USE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BLOCK_SIZE:    block_size    <= cfg_data;
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    limit <= 32'(block_size) * 32'(blocks_in_use);
  end

  // table memory, one write port, one registered read port
  assign slot_ok = ({26'b0, in_data.entry_index} < 32'(TABLE_DEPTH));
  assign mem_we  = cmd.clear_step | (cmd.load & slot_ok);
  assign mem_wa  = cmd.clear_step ? i_cnt[AW-1:0] : AW'(in_data.entry_index);
  assign mem_wd  = cmd.clear_step ? END_MARK : in_data.entry_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[i_cnt[AW-1:0]];
  end

  // restoring divider, one quotient bit per cycle
  assign trial    = {rem, addr_q[31]};
  assign trial_ge = (trial >= {1'b0, block_size});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_q  <= in_data.logical_address;
      rem     <= 16'd0;
      div_cnt <= 5'd0;
    end else if (cmd.div_step) begin
      addr_q  <= {addr_q[30:0], trial_ge};
      rem     <= trial_ge ? 16'(trial - {1'b0, block_size}) : trial[15:0];
      div_cnt <= div_cnt + 5'd1;
    end
  end

  // walk counters; i_cnt also sweeps the table during the clear pass
  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt    <= '0;
      restarts <= '0;
    end else if (cmd.clear_step || cmd.walk_next) begin
      i_cnt <= i_cnt + CW'(1);
    end else if (cmd.walk_init) begin
      i_cnt    <= '0;
      restarts <= '0;
    end else if (cmd.walk_hit) begin
      i_cnt    <= '0;
      restarts <= restarts + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      blk <= addr_q[15:0];
    end else if (cmd.walk_hit) begin
      blk <= blocks_in_use + 16'(i_cnt) + 16'd1;
    end
    if (cmd.mul) begin
      prod <= 32'(blk) * 32'(block_size);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_zero) begin
      res_addr <= 32'd0;
      res_blk  <= 16'd0;
      res_st   <= cmd.res_code;
    end else if (cmd.res_ok) begin
      res_addr <= prod + {16'd0, rem};
      res_blk  <= blk;
      res_st   <= ST_OK;
    end
    if (cmd.emit) begin
      out_data.phys_address <= res_addr;
      out_data.phys_block   <= res_blk;
      out_data.status       <= res_st;
    end
  end

  always_comb begin
    sts.clear_done = (i_cnt == CW'(TABLE_DEPTH - 1));
    sts.range_bad  = (addr_q >= limit);
    sts.div_last   = (div_cnt == 5'd31);
    sts.i_at_end   = (i_cnt == CW'(TABLE_DEPTH));
    sts.entry_end  = (rd_data == END_MARK);
    sts.entry_hit  = (rd_data == blk);
    sts.loop_bound = (restarts == RW'(TABLE_DEPTH));
  end

endmodule

[src/fbbr_ctrl.sv]
// ----------------------------------------------------------------------------
// fbbr_ctrl: remapper controller
// Sequences table clear, load, range check, division, table walk and result
// hand-off; owns the input stall and output valid.
// ----------------------------------------------------------------------------
module fbbr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_cmd,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  fbbr_pkg::fbbr_sts_t sts,
  output fbbr_pkg::fbbr_cmd_t cmd
);
  import fbbr_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_CHECK    = 10'b00_0000_0100,
    S_DIV      = 10'b00_0000_1000,
    S_WSTART   = 10'b00_0001_0000,
    S_WALK_RD  = 10'b00_0010_0000,
    S_WALK_CMP = 10'b00_0100_0000,
    S_MUL      = 10'b00_1000_0000,
    S_ADD      = 10'b01_0000_0000,
    S_EMIT     = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_LOAD) begin
            cmd.load     = 1'b1;
            cmd.res_zero = 1'b1;
            cmd.res_code = ST_OK;
            state_next   = S_EMIT;
          end else begin
            cmd.accept = 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.range_bad) begin
          cmd.res_zero = 1'b1;
          cmd.res_code = ST_RANGE;
          state_next   = S_EMIT;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_WSTART;
      end
      S_WSTART: begin
        cmd.walk_init = 1'b1;
        state_next    = S_WALK_RD;
      end
      S_WALK_RD: begin
        // read address is the slot counter; data is back next cycle
        state_next = sts.i_at_end ? S_MUL : S_WALK_CMP;
      end
      S_WALK_CMP: begin
        if (sts.entry_end) begin
          state_next = S_MUL;
        end else if (sts.entry_hit) begin
          if (sts.loop_bound) begin
            cmd.res_zero = 1'b1;
            cmd.res_code = ST_LOOP;
            state_next   = S_EMIT;
          end else begin
            cmd.walk_hit = 1'b1;
            state_next   = S_WALK_RD;
          end
        end else begin
          cmd.walk_next = 1'b1;
          state_next    = S_WALK_RD;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.res_ok = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[src/flash_bad_block_remapper.sv]
// ----------------------------------------------------------------------------
// flash_bad_block_remapper: logical to physical flash address translation
// Input transactions (in_valid/in_stall) either load one bad-block table slot
// or translate a logical byte address; every transaction returns exactly one
// result on out_valid/out_stall. block_size and blocks_in_use are written
// through cfg_wr_en/cfg_index/cfg_data; the user must write them only while
// the block is idle, as the block itself does not enforce this.
// One transaction is processed at a time; in_stall is high while busy.
// A load writes its slot, if in range, and sets a zero OK result when it is
// accepted, then hands the result on from the emit state. A translate runs
// the range check, the one-bit-per-cycle divider, then the walk, which reads
// the table once per slot and restarts at slot 0 on each remap, then the
// multiply and add. After reset the table is swept to 0xFFFF slot by slot
// with in_stall high; config writes are taken during the sweep. The finished
// result sits in an output register; while the receiver stalls, the next
// transaction can be accepted and processed, and the controller holds its
// result until the output register frees.
// ----------------------------------------------------------------------------
module flash_bad_block_remapper #(
  parameter int TABLE_DEPTH = fbbr_pkg::DEF_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  fbbr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fbbr_pkg::out_item_t out_data
);
  import fbbr_pkg::*;

  fbbr_cmd_t cmd;
  fbbr_sts_t sts;

  fbbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbbr_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
